### sv/dcp_pkg.sv
// dcp_pkg: widths, constants and sideband types of the distance constraint
// projection pipeline. No dependencies; used by every file of the block.
package dcp_pkg;

   localparam int POS_W   = 32;
   localparam int MASS_W  = 32;
   localparam int REST_W  = 31;
   localparam int STIFF_W = 17;
   localparam int DIFF_W  = 33;
   localparam int SUM_W   = 66;
   localparam int LEN_W   = 34;
   localparam int DMAG_W  = 35;
   localparam int NRM_W   = 17;
   localparam int KN_W    = 34;
   localparam int PROD_W  = 69;
   localparam int WSUM_W  = 33;
   localparam int CMAG_W  = 53;
   localparam int CLO_W   = 27;
   localparam int MOVE_W  = 48;
   localparam int ACC_W   = 50;
   localparam int TAG_MAX = 16;

   localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;

   typedef enum logic [0:0] {
      CSR_COMPRESS = 1'b0,
      CSR_STRETCH  = 1'b1
   } csr_index_type;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type [5:0]                pos;
      logic [MASS_W-1:0]            w1;
      logic [MASS_W-1:0]            w2;
      logic [REST_W-1:0]            rest;
      logic [WSUM_W-1:0]            wsum;
      logic [2:0][DIFF_W-1:0]       amag;
      logic [2:0]                   dneg;
   } side_a_type;

   typedef struct packed {
      pos_type [5:0]                pos;
      logic [MASS_W-1:0]            w1;
      logic [MASS_W-1:0]            w2;
      logic [WSUM_W-1:0]            wsum;
      logic [STIFF_W-1:0]           k;
      logic [DMAG_W-1:0]            dmag;
      logic                         dneg;
      logic [2:0]                   nneg;
      logic                         len_zero;
   } side_b_type;

   typedef struct packed {
      pos_type [5:0]                pos;
      logic [MASS_W-1:0]            w1;
      logic [MASS_W-1:0]            w2;
      logic [2:0]                   cneg;
      logic                         wsum_nz;
   } side_c_type;

endpackage

### sv/dcp_sqrt.sv
// dcp_sqrt: pipelined integer square root, one root bit per register stage.
// Depends on dcp_pkg for the radicand and root widths.
module dcp_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [dcp_pkg::SUM_W-1:0]    rad,
   output logic [dcp_pkg::LEN_W-1:0]    root
);
   import dcp_pkg::*;

   localparam int STEPS = LEN_W;
   localparam int PAD_W = 2 * LEN_W;
   localparam int RW    = LEN_W + 2;

   logic [RW-1:0]    rem_ff  [STEPS-1];
   logic [PAD_W-1:0] rad_ff  [STEPS-1];
   logic [LEN_W-1:0] root_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [RW-1:0]    rem_prev;
      logic [PAD_W-1:0] rad_prev;
      logic [LEN_W-1:0] root_prev;
      logic [RW+1:0]    acc;
      logic [RW+1:0]    trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = PAD_W'(rad);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      assign acc   = {rem_prev, rad_prev[PAD_W-1 -: 2]};
      assign trial = (RW + 2)'({root_prev, 2'b01});
      assign ge    = acc >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= {root_prev[LEN_W-2:0], ge};
         end
      end

      if (i < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? RW'(acc - trial) : RW'(acc);
               rad_ff[i] <= {rad_prev[PAD_W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule

### sv/dcp_div.sv
// dcp_div: pipelined restoring divider, one quotient bit per register stage.
// The numerator bits above the quotient must be below the divisor.
module dcp_div #(
   parameter int NW = 49,
   parameter int DW = 34,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   import dcp_pkg::*;

   logic [DW-1:0] rem_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] w_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] w_prev;
      logic [DW:0]   acc;
      logic          ge;

      if (i == 0) begin : g_first
         assign rem_prev = DW'(num[NW-1:QW]);
         assign den_prev = den;
         assign w_prev   = num[QW-1:0];
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign w_prev   = w_ff[i-1];
      end

      assign acc = {rem_prev, w_prev[QW-1]};
      assign ge  = acc >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[i] <= {w_prev[QW-2:0], ge};
         end
      end

      if (i < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? DW'(acc - {1'b0, den_prev}) : acc[DW-1:0];
               den_ff[i] <= den_prev;
            end
         end
      end
   end

   assign quo = w_ff[QW-1];

endmodule

### sv/distance_constraint_projection.sv
// distance_constraint_projection: distance constraint projection on one pair.
// One pair per cycle sustained while the result is not stalled.
// Depth is set by the 34-stage square root and the 17- and 53-stage dividers.
// A stalled result holds the whole pipeline, so input stops only then.
// Synchronous reset empties the pipeline and sets both stiffness values to 1.0.
// Depends on dcp_pkg, dcp_sqrt and dcp_div.
module distance_constraint_projection #(
   parameter int TAG_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [0:0]                               csr_index,
   input  logic [dcp_pkg::STIFF_W-1:0]              csr_wdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // pair_tag, first_x, first_y, first_z, second_x, second_y, second_z,
   // first_inv_mass, second_inv_mass, rest_length, zero pad
   input  logic [((TAG_BITS + 287 + 7) / 8) * 8-1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // out_tag, new_first_x, new_first_y, new_first_z, new_second_x,
   // new_second_y, new_second_z, zero pad
   output logic [((TAG_BITS + 192 + 7) / 8) * 8-1:0] rsp_tdata,
   // applied
   output logic [0:0]                               rsp_tuser
);
   import dcp_pkg::*;

   localparam int RSP_W    = ((TAG_BITS + 192 + 7) / 8) * 8;
   localparam int SQ_LAT   = LEN_W;
   localparam int N_Q      = NRM_W;
   localparam int C_Q      = CMAG_W;
   localparam int LAT      = 4 + SQ_LAT + 1 + N_Q + 2 + C_Q + 3;
   localparam int TAG_KEEP = (TAG_BITS < TAG_MAX) ? TAG_BITS : TAG_MAX;
   localparam logic [TAG_BITS-1:0] TAG_MASK = TAG_BITS'((64'd1 << TAG_KEEP) - 64'd1);

   function automatic pos_type sat_pos(input logic signed [ACC_W-1:0] v);
      pos_type r;
      if (v > $signed(ACC_W'(32'sh7FFF_FFFF))) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -$signed(ACC_W'(33'sh0_8000_0000))) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   logic en;

   // configuration
   logic [STIFF_W-1:0] compress_ff, compress_in;
   logic [STIFF_W-1:0] stretch_ff, stretch_in;

   always_comb begin
      compress_in = compress_ff;
      stretch_in  = stretch_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COMPRESS: compress_in = csr_wdata;
            CSR_STRETCH:  stretch_in  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_ff <= STIFF_RESET;
         stretch_ff  <= STIFF_RESET;
      end else begin
         compress_ff <= compress_in;
         stretch_ff  <= stretch_in;
      end
   end

   // valid and tag lines
   logic                vld_ff [LAT];
   logic [TAG_BITS-1:0] tag_ff [LAT];

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= req_tdata[TAG_BITS-1:0] & TAG_MASK;
         for (int i = 1; i < LAT; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   // stage 1: input register
   pos_type [5:0]      pos1_ff;
   logic [MASS_W-1:0]  w1_1_ff, w2_1_ff;
   logic [REST_W-1:0]  rest1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) pos1_ff[j] <= req_tdata[TAG_BITS + POS_W*j +: POS_W];
         w1_1_ff  <= req_tdata[TAG_BITS + 192 +: MASS_W];
         w2_1_ff  <= req_tdata[TAG_BITS + 224 +: MASS_W];
         rest1_ff <= req_tdata[TAG_BITS + 256 +: REST_W];
      end
   end

   // stage 2: differences and magnitudes
   side_a_type side2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            logic signed [DIFF_W-1:0] d;
            d = DIFF_W'($signed(pos1_ff[j])) - DIFF_W'($signed(pos1_ff[j+3]));
            side2_ff.amag[j] <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            side2_ff.dneg[j] <= d[DIFF_W-1];
         end
         side2_ff.pos  <= pos1_ff;
         side2_ff.w1   <= w1_1_ff;
         side2_ff.w2   <= w2_1_ff;
         side2_ff.rest <= rest1_ff;
         side2_ff.wsum <= WSUM_W'(w1_1_ff) + WSUM_W'(w2_1_ff);
      end
   end

   // stage 3: squares, stage 4: sum of squares
   logic [SUM_W-1:0] sq3_ff [3];
   side_a_type       side3_ff, side4_ff;
   logic [SUM_W-1:0] sum4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            sq3_ff[j] <= SUM_W'(side2_ff.amag[j]) * SUM_W'(side2_ff.amag[j]);
         end
         side3_ff <= side2_ff;
         sum4_ff  <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         side4_ff <= side3_ff;
      end
   end

   // square root and aligned sideband
   logic [LEN_W-1:0] len_w;
   side_a_type       sidea_ff [SQ_LAT];

   dcp_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum4_ff),
      .root  (len_w)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sidea_ff[0] <= side4_ff;
         for (int i = 1; i < SQ_LAT; i++) sidea_ff[i] <= sidea_ff[i-1];
      end
   end

   // stage 39: stiffness select and length error
   side_a_type         a39_ff;
   logic [LEN_W-1:0]   len39_ff;
   logic [STIFF_W-1:0] k39_ff;
   logic [DMAG_W-1:0]  dmag39_ff;
   logic               dneg39_ff;
   logic               lenz39_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         logic lt;
         lt = len_w < LEN_W'(sidea_ff[SQ_LAT-1].rest);
         a39_ff    <= sidea_ff[SQ_LAT-1];
         len39_ff  <= len_w;
         k39_ff    <= lt ? compress_ff : stretch_ff;
         dmag39_ff <= lt ? DMAG_W'(sidea_ff[SQ_LAT-1].rest) - DMAG_W'(len_w)
                         : DMAG_W'(len_w) - DMAG_W'(sidea_ff[SQ_LAT-1].rest);
         dneg39_ff <= lt;
         lenz39_ff <= len_w == '0;
      end
   end

   // direction dividers
   logic [NRM_W-1:0] nq_w [3];
   side_b_type       sideb_in;
   side_b_type       sideb_ff [N_Q];

   for (genvar j = 0; j < 3; j++) begin : g_ndiv
      dcp_div #(
         .NW (DIFF_W + 16),
         .DW (LEN_W),
         .QW (NRM_W)
      ) u_ndiv (
         .clock (clock),
         .en    (en),
         .num   ({a39_ff.amag[j], 16'h0000}),
         .den   (len39_ff),
         .quo   (nq_w[j])
      );
   end

   always_comb begin
      sideb_in.pos      = a39_ff.pos;
      sideb_in.w1       = a39_ff.w1;
      sideb_in.w2       = a39_ff.w2;
      sideb_in.wsum     = a39_ff.wsum;
      sideb_in.k        = k39_ff;
      sideb_in.dmag     = dmag39_ff;
      sideb_in.dneg     = dneg39_ff;
      sideb_in.nneg     = a39_ff.dneg;
      sideb_in.len_zero = lenz39_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sideb_ff[0] <= sideb_in;
         for (int i = 1; i < N_Q; i++) sideb_ff[i] <= sideb_ff[i-1];
      end
   end

   // stage 57: stiffness times direction, stage 58: times length error
   logic [KN_W-1:0]   kn57_ff [3];
   side_b_type        side57_ff;
   logic [PROD_W-1:0] prod58_ff [3];
   logic [WSUM_W-1:0] wsum58_ff;
   side_c_type        side58_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            logic [NRM_W-1:0] nmag;
            nmag = sideb_ff[N_Q-1].len_zero ? '0 : nq_w[j];
            kn57_ff[j] <= KN_W'(sideb_ff[N_Q-1].k) * KN_W'(nmag);
         end
         side57_ff <= sideb_ff[N_Q-1];
         for (int j = 0; j < 3; j++) begin
            prod58_ff[j] <= PROD_W'(kn57_ff[j]) * PROD_W'(side57_ff.dmag);
         end
         wsum58_ff         <= side57_ff.wsum;
         side58_ff.pos     <= side57_ff.pos;
         side58_ff.w1      <= side57_ff.w1;
         side58_ff.w2      <= side57_ff.w2;
         side58_ff.cneg    <= side57_ff.nneg ^ {3{side57_ff.dneg}};
         side58_ff.wsum_nz <= side57_ff.wsum != '0;
      end
   end

   // correction dividers
   logic [CMAG_W-1:0] cq_w [3];
   side_c_type        sidec_ff [C_Q];

   for (genvar j = 0; j < 3; j++) begin : g_cdiv
      dcp_div #(
         .NW (CMAG_W + 1),
         .DW (WSUM_W),
         .QW (CMAG_W)
      ) u_cdiv (
         .clock (clock),
         .en    (en),
         .num   ({1'b0, prod58_ff[j][PROD_W-1:16]}),
         .den   (wsum58_ff),
         .quo   (cq_w[j])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidec_ff[0] <= side58_ff;
         for (int i = 1; i < C_Q; i++) sidec_ff[i] <= sidec_ff[i-1];
      end
   end

   // stage 112: partial products of the moves
   localparam int CHI_W = CMAG_W - CLO_W;
   logic [MASS_W+CLO_W-1:0] p1lo_ff [3];
   logic [MASS_W+CHI_W-1:0] p1hi_ff [3];
   logic [MASS_W+CLO_W-1:0] p2lo_ff [3];
   logic [MASS_W+CHI_W-1:0] p2hi_ff [3];
   side_c_type              side112_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            p1lo_ff[j] <= (MASS_W + CLO_W)'(sidec_ff[C_Q-1].w1)
                          * (MASS_W + CLO_W)'(cq_w[j][CLO_W-1:0]);
            p1hi_ff[j] <= (MASS_W + CHI_W)'(sidec_ff[C_Q-1].w1)
                          * (MASS_W + CHI_W)'(cq_w[j][CMAG_W-1:CLO_W]);
            p2lo_ff[j] <= (MASS_W + CLO_W)'(sidec_ff[C_Q-1].w2)
                          * (MASS_W + CLO_W)'(cq_w[j][CLO_W-1:0]);
            p2hi_ff[j] <= (MASS_W + CHI_W)'(sidec_ff[C_Q-1].w2)
                          * (MASS_W + CHI_W)'(cq_w[j][CMAG_W-1:CLO_W]);
         end
         side112_ff <= sidec_ff[C_Q-1];
      end
   end

   // stage 113: moves, product kept to 64 bits
   logic [MOVE_W-1:0] m1_ff [3];
   logic [MOVE_W-1:0] m2_ff [3];
   side_c_type        side113_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            logic [63:0] s1, s2;
            s1 = 64'(p1lo_ff[j]) + (64'(p1hi_ff[j]) << CLO_W);
            s2 = 64'(p2lo_ff[j]) + (64'(p2hi_ff[j]) << CLO_W);
            m1_ff[j] <= s1[63:16];
            m2_ff[j] <= s2[63:16];
         end
         side113_ff <= side112_ff;
      end
   end

   // stage 114: new positions with saturation
   pos_type [5:0] out_pos_ff;
   logic          applied_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            logic signed [ACC_W-1:0] b1, b2, mv1, mv2;
            b1  = ACC_W'($signed(side113_ff.pos[j]));
            b2  = ACC_W'($signed(side113_ff.pos[j+3]));
            mv1 = $signed(ACC_W'(m1_ff[j]));
            mv2 = $signed(ACC_W'(m2_ff[j]));
            out_pos_ff[j]   <= (side113_ff.w1 != '0)
                               ? sat_pos(side113_ff.cneg[j] ? b1 + mv1 : b1 - mv1)
                               : side113_ff.pos[j];
            out_pos_ff[j+3] <= (side113_ff.w2 != '0)
                               ? sat_pos(side113_ff.cneg[j] ? b2 - mv2 : b2 + mv2)
                               : side113_ff.pos[j+3];
         end
         applied_ff <= side113_ff.wsum_nz;
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = RSP_W'({out_pos_ff, tag_ff[LAT-1]});
   assign rsp_tuser  = applied_ff;

   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transfer did not enter the pipeline");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && en |=> rsp_tvalid)
      else $error("item lost before the result register");

endmodule

### dv/distance_constraint_projection_tb.sv
// distance_constraint_projection_tb: self-checking bench for the pair projection block.
// Bursty request source, stalling response sink, in-bench fixed-point predictor.
// Depends on dcp_pkg and distance_constraint_projection.
`timescale 1ns / 100ps

module distance_constraint_projection_tb;
   import dcp_pkg::*;

   localparam int REQ_W = 304;
   localparam int RSP_W = 208;

   typedef struct {
      logic [15:0]       tag;
      pos_type           pos [6];
      logic [MASS_W-1:0] w1;
      logic [MASS_W-1:0] w2;
      logic [REST_W-1:0] rest;
   } pair_type;

   typedef struct {
      logic [15:0] tag;
      pos_type     pos [6];
      logic        applied;
   } moved_type;

   // check: 0 predictor, 1 unchanged and not applied, 2 unchanged and applied
   typedef struct {
      pair_type pair;
      int       check;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [0:0]        csr_index = CSR_COMPRESS;
   logic [STIFF_W-1:0] csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [0:0]        rsp_tuser;

   logic [STIFF_W-1:0] compress_k = STIFF_RESET;
   logic [STIFF_W-1:0] stretch_k  = STIFF_RESET;
   moved_type          moved_q [$];
   int                 errors = 0;
   int                 burst_left = 0;

   distance_constraint_projection dut (.*);

   always #4 clock = ~clock;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic moved_type project_pair(pair_type pr);
      moved_type   res;
      longint      p [6];
      longint      d, delta, m1, m2;
      logic [127:0] s, len, c, amag, nmag, cmag, dmag, k, wsum;
      logic        dneg, nneg, cneg;
      res.tag = pr.tag;
      res.applied = 1'b0;
      for (int i = 0; i < 6; i++) p[i] = longint'(pr.pos[i]);
      wsum = 128'(pr.w1) + 128'(pr.w2);
      if (wsum != 0) begin
         s = 0;
         for (int i = 0; i < 3; i++) begin
            d = p[i] - p[3+i];
            amag = 128'(d < 0 ? -d : d);
            s = s + amag * amag;
         end
         len = 0;
         for (int b = 33; b >= 0; b--) begin
            c = len | (128'd1 << b);
            if (c * c <= s) len = c;
         end
         k = (len < 128'(pr.rest)) ? 128'(compress_k) : 128'(stretch_k);
         delta = longint'(len[63:0]) - longint'(pr.rest);
         dneg = delta < 0;
         dmag = 128'(dneg ? -delta : delta);
         for (int i = 0; i < 3; i++) begin
            d = p[i] - p[3+i];
            nneg = d < 0;
            amag = 128'(nneg ? -d : d);
            nmag = (len != 0) ? (amag << 16) / len : 0;
            cmag = (k * nmag * dmag) / (wsum << 16);
            cneg = nneg != dneg;
            // move product wraps at 64 bits before the shift
            m1 = longint'(64'(128'(pr.w1) * cmag) >> 16);
            m2 = longint'(64'(128'(pr.w2) * cmag) >> 16);
            if (pr.w1 != 0) p[i] += cneg ? m1 : -m1;
            if (pr.w2 != 0) p[3+i] += cneg ? -m2 : m2;
            p[i] = sat32(p[i]);
            p[3+i] = sat32(p[3+i]);
         end
         res.applied = 1'b1;
      end
      for (int i = 0; i < 6; i++) res.pos[i] = pos_type'(p[i]);
      return res;
   endfunction

   function automatic logic [REQ_W-1:0] pack_pair(pair_type pr);
      logic [REQ_W-1:0] v;
      v = '0;
      v[15:0] = pr.tag;
      for (int i = 0; i < 6; i++) v[16 + 32*i +: 32] = pr.pos[i];
      v[208 +: 32] = pr.w1;
      v[240 +: 32] = pr.w2;
      v[272 +: 31] = pr.rest;
      return v;
   endfunction

   function automatic pair_type random_pair();
      pair_type pr;
      int       span;
      logic signed [31:0] centre;
      pr.tag = $urandom;
      span = $urandom_range(4, 24);
      centre = $urandom;
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 7) == 0) pr.pos[i] = $urandom;
         else pr.pos[i] = centre + $signed($urandom_range(0, 2 << span)) - (1 << span);
      end
      case ($urandom_range(0, 5))
         0: begin pr.w1 = 0; pr.w2 = $urandom_range(1, 1 << 18); end
         1: begin pr.w1 = $urandom_range(1, 1 << 18); pr.w2 = 0; end
         2: begin pr.w1 = $urandom; pr.w2 = $urandom; end
         3: begin pr.w1 = 0; pr.w2 = 0; end
         default: begin
            pr.w1 = $urandom_range(1, 1 << 18);
            pr.w2 = $urandom_range(1, 1 << 18);
         end
      endcase
      if ($urandom_range(0, 5) == 0) pr.rest = $urandom;
      else pr.rest = $urandom_range(0, 2 << span);
      return pr;
   endfunction

   task automatic send_pair(pair_type pr, int check);
      moved_type mv;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pack_pair(pr);
      do @(posedge clock); while (!req_tready);
      if (check == 0) mv = project_pair(pr);
      else begin
         mv.tag = pr.tag;
         mv.pos = pr.pos;
         mv.applied = (check == 2);
      end
      moved_q.insert(moved_q.size(), mv);
   endtask

   task automatic set_stiffness(logic [STIFF_W-1:0] kc, logic [STIFF_W-1:0] ks);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (moved_q.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COMPRESS;
      csr_wdata <= kc;
      @(posedge clock);
      csr_index <= CSR_STRETCH;
      csr_wdata <= ks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      compress_k = kc;
      stretch_k  = ks;
   endtask

   // response sink stall pattern, switching between modes
   int stall_mode = 0;
   int stall_count = 0;
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (stall_count % 7) < 3;
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   always @(posedge clock) begin
      moved_type exp_mv;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (moved_q.size() == 0) begin
            $display("%0t: unexpected transfer, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_mv = moved_q.pop_front();
            if (rsp_tdata[15:0] !== exp_mv.tag) begin
               $display("%0t: tag expected %h actual %h", $time, exp_mv.tag,
                        rsp_tdata[15:0]);
               errors++;
            end
            for (int i = 0; i < 6; i++)
               if (rsp_tdata[16 + 32*i +: 32] !== exp_mv.pos[i]) begin
                  $display("%0t: tag %h position %0d expected %h actual %h", $time,
                           exp_mv.tag, i, exp_mv.pos[i], rsp_tdata[16 + 32*i +: 32]);
                  errors++;
               end
            if (rsp_tuser[0] !== exp_mv.applied) begin
               $display("%0t: tag %h applied expected %b actual %b", $time,
                        exp_mv.tag, exp_mv.applied, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      row_type rows [$];
      row_type rw;
      pos_type maxp, minp;
      maxp = 32'sh7FFFFFFF;
      minp = 32'sh80000000;
      // zero mass sum passes through, extremes of every field
      rw.pair = '{16'hFFFF, '{maxp, minp, maxp, minp, maxp, minp}, 0, 0, 31'h7FFFFFFF};
      rw.check = 1; rows.insert(rows.size(), rw);
      rw.pair = '{16'h0000, '{minp, maxp, minp, maxp, minp, maxp}, 0, 0, 0};
      rw.check = 1; rows.insert(rows.size(), rw);
      // zero length keeps positions but is applied
      rw.pair = '{16'h0001, '{32'sd5, -32'sd7, 32'sd9, 32'sd5, -32'sd7, 32'sd9},
                  32'h10000, 32'h10000, 31'h10000};
      rw.check = 2; rows.insert(rows.size(), rw);
      rw.pair = '{16'h0002, '{maxp, maxp, maxp, maxp, maxp, maxp},
                  32'hFFFFFFFF, 32'hFFFFFFFF, 0};
      rw.check = 2; rows.insert(rows.size(), rw);
      // stretch, compress, one side fixed, saturation
      rw.check = 0;
      rw.pair = '{16'h0003, '{32'sh30000, 0, 0, 0, 0, 0}, 32'h10000, 32'h10000, 31'h10000};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0004, '{32'sh10000, 0, 0, 0, 0, 0}, 32'h10000, 32'h10000, 31'h40000};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0005, '{0, 32'sh20000, 0, 0, 0, 0}, 0, 32'h10000, 31'h10000};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0006, '{0, 0, 32'sh20000, 0, 0, 0}, 32'h10000, 0, 31'h50000};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0007, '{maxp, 0, 0, minp, 0, 0}, 32'hFFFFFFFF, 32'hFFFFFFFF, 0};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0008, '{maxp, maxp, maxp, minp, minp, minp}, 32'hFFFFFFFF, 1,
                  31'h7FFFFFFF};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h0009, '{minp, 0, maxp, maxp, 0, minp}, 1, 32'hFFFFFFFF, 0};
      rows.insert(rows.size(), rw);
      rw.pair = '{16'h000A, '{-32'sd3, 32'sd4, 0, 0, 0, 0}, 32'h8000, 32'h18000, 31'd5};
      rows.insert(rows.size(), rw);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_pair(rows[i].pair, rows[i].check);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_stiffness(0, 17'h1FFFF);
            1: set_stiffness(17'h1FFFF, 0);
            2: set_stiffness(17'd32768, 17'd98304);
            3: set_stiffness($urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF));
            default: set_stiffness(STIFF_RESET, STIFF_RESET);
         endcase
         repeat (190) send_pair(random_pair(), 0);
      end
      req_tvalid <= 1'b0;
      while (moved_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
sv/dcp_pkg.sv
sv/dcp_sqrt.sv
sv/dcp_div.sv
sv/distance_constraint_projection.sv
dv/distance_constraint_projection_tb.sv
